// ----- hdl/tsm_pkg.sv -----
package tsm_pkg;

   localparam int unsigned STORE_DEPTH_DEF = 1024;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned STEP_W = 5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] SEL_BOTTOM = 2'd0;
   localparam logic [1:0] SEL_TOP    = 2'd1;

   typedef logic [STEP_W-1:0] step_type;

   // microprogram step addresses
   localparam step_type UC_IDLE     = 5'd0;
   localparam step_type UC_DISPATCH = 5'd1;
   localparam step_type UC_DONE     = 5'd2;
   localparam step_type UC_BPU0     = 5'd3;
   localparam step_type UC_BPU1     = 5'd4;
   localparam step_type UC_BPU2     = 5'd5;
   localparam step_type UC_BPO0     = 5'd6;
   localparam step_type UC_BPO1     = 5'd7;
   localparam step_type UC_BPO2     = 5'd8;
   localparam step_type UC_BPO3     = 5'd9;
   localparam step_type UC_TPU0     = 5'd10;
   localparam step_type UC_TPO0     = 5'd11;
   localparam step_type UC_TPO1     = 5'd12;
   localparam step_type UC_MPU0     = 5'd13;
   localparam step_type UC_MPU1     = 5'd14;
   localparam step_type UC_MPU2     = 5'd15;
   localparam step_type UC_MPU3     = 5'd16;
   localparam step_type UC_MPU4     = 5'd17;
   localparam step_type UC_MPO0     = 5'd18;
   localparam step_type UC_MPO1     = 5'd19;
   localparam step_type UC_MPO2     = 5'd20;
   localparam step_type UC_MPO3     = 5'd21;
   localparam step_type UC_MPO4     = 5'd22;
   localparam step_type UC_LAST     = UC_MPO4;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      K_BOT_PUSH,
      K_BOT_POP,
      K_TOP_PUSH,
      K_TOP_POP,
      K_MID_PUSH,
      K_MID_POP
   } kind_type;

   typedef enum logic [3:0] {
      A_BC,       // bottom_count
      A_BCM1,     // bottom_count - 1
      A_TOPW,     // next free word of the top stack
      A_TOPR,     // top word of the top stack
      A_BASE,
      A_BASEM1,
      A_END,      // base + length
      A_ENDM1,
      A_END_R1,   // logical top of the middle stack
      A_PTR,
      A_PTRM1,
      A_PTRP1
   } addr_sel_type;

   typedef enum logic {
      WD_VALUE,
      WD_RAM
   } wdata_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LOAD_END,
      PTR_LOAD_SLOT,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [3:0] {
      UPD_NONE,
      UPD_BOT_INC,
      UPD_BOT_DEC,
      UPD_TOP_INC,
      UPD_TOP_DEC,
      UPD_SLIDE_UP,
      UPD_SLIDE_DOWN,
      UPD_MID_FIRST,
      UPD_MID_INC,
      UPD_MID_DEC
   } upd_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_LEN_ZERO,
      C_PTR_SLOT,
      C_PTR_LAST,
      C_DISPATCH
   } cond_type;

   typedef struct packed {
      logic          is_idle;
      logic          is_done;
      addr_sel_type  rd_sel;
      logic          wr_en;
      addr_sel_type  wr_sel;
      wdata_sel_type wd_sel;
      ptr_op_type    ptr_op;
      logic          res_load;
      upd_type       upd;
      cond_type      cond;
      step_type      target;
   } ctrl_type;

   typedef struct packed {
      kind_type kind;
      logic     err;
      logic     len_zero;
      logic     ptr_at_slot;
      logic     ptr_at_last;
   } flags_type;

   localparam ctrl_type CTRL_NOP = '{
      is_idle:  1'b0,
      is_done:  1'b0,
      rd_sel:   A_BC,
      wr_en:    1'b0,
      wr_sel:   A_BC,
      wd_sel:   WD_VALUE,
      ptr_op:   PTR_HOLD,
      res_load: 1'b0,
      upd:      UPD_NONE,
      cond:     C_NEXT,
      target:   UC_IDLE
   };

   // control store
   function automatic ctrl_type uc_word(step_type step);
      ctrl_type w;
      w = CTRL_NOP;
      case (step)
         UC_IDLE: begin
            w.is_idle = 1'b1;
         end
         UC_DISPATCH: begin
            w.cond = C_DISPATCH;
         end
         UC_DONE: begin
            w.is_done = 1'b1;
         end
         // bottom push: move first middle word to the end, then store
         UC_BPU0: begin
            w.rd_sel = A_BASE;
            w.cond   = C_LEN_ZERO;
            w.target = UC_BPU2;
         end
         UC_BPU1: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_END;
            w.wd_sel = WD_RAM;
            w.upd    = UPD_SLIDE_UP;
         end
         UC_BPU2: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_BC;
            w.wd_sel = WD_VALUE;
            w.upd    = UPD_BOT_INC;
            w.cond   = C_ALWAYS;
            w.target = UC_DONE;
         end
         // bottom pop: take the word, then move last middle word below
         UC_BPO0: begin
            w.rd_sel = A_BCM1;
         end
         UC_BPO1: begin
            w.res_load = 1'b1;
            w.rd_sel   = A_ENDM1;
            w.cond     = C_LEN_ZERO;
            w.target   = UC_BPO3;
         end
         UC_BPO2: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_BASEM1;
            w.wd_sel = WD_RAM;
            w.upd    = UPD_SLIDE_DOWN;
         end
         UC_BPO3: begin
            w.upd    = UPD_BOT_DEC;
            w.cond   = C_ALWAYS;
            w.target = UC_DONE;
         end
         UC_TPU0: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_TOPW;
            w.wd_sel = WD_VALUE;
            w.upd    = UPD_TOP_INC;
            w.cond   = C_ALWAYS;
            w.target = UC_DONE;
         end
         UC_TPO0: begin
            w.rd_sel = A_TOPR;
         end
         UC_TPO1: begin
            w.res_load = 1'b1;
            w.upd      = UPD_TOP_DEC;
            w.cond     = C_ALWAYS;
            w.target   = UC_DONE;
         end
         // middle push: shift words above the logical top up by one
         UC_MPU0: begin
            w.ptr_op = PTR_LOAD_END;
            w.cond   = C_LEN_ZERO;
            w.target = UC_MPU4;
         end
         UC_MPU1: begin
            w.rd_sel = A_PTRM1;
            w.cond   = C_PTR_SLOT;
            w.target = UC_MPU3;
         end
         UC_MPU2: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_PTR;
            w.wd_sel = WD_RAM;
            w.ptr_op = PTR_DEC;
            w.cond   = C_ALWAYS;
            w.target = UC_MPU1;
         end
         UC_MPU3: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_PTR;
            w.wd_sel = WD_VALUE;
            w.upd    = UPD_MID_INC;
            w.cond   = C_ALWAYS;
            w.target = UC_DONE;
         end
         UC_MPU4: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_BC;
            w.wd_sel = WD_VALUE;
            w.upd    = UPD_MID_FIRST;
            w.cond   = C_ALWAYS;
            w.target = UC_DONE;
         end
         // middle pop: take the logical top, shift the words above down
         UC_MPO0: begin
            w.rd_sel = A_END_R1;
            w.ptr_op = PTR_LOAD_SLOT;
         end
         UC_MPO1: begin
            w.res_load = 1'b1;
         end
         UC_MPO2: begin
            w.rd_sel = A_PTRP1;
            w.cond   = C_PTR_LAST;
            w.target = UC_MPO4;
         end
         UC_MPO3: begin
            w.wr_en  = 1'b1;
            w.wr_sel = A_PTR;
            w.wd_sel = WD_RAM;
            w.ptr_op = PTR_INC;
            w.cond   = C_ALWAYS;
            w.target = UC_MPO2;
         end
         UC_MPO4: begin
            w.upd    = UPD_MID_DEC;
            w.cond   = C_ALWAYS;
            w.target = UC_DONE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = UC_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic step_type entry_of(kind_type kind);
      step_type s;
      case (kind)
         K_BOT_PUSH: s = UC_BPU0;
         K_BOT_POP:  s = UC_BPO0;
         K_TOP_PUSH: s = UC_TPU0;
         K_TOP_POP:  s = UC_TPO0;
         K_MID_PUSH: s = UC_MPU0;
         K_MID_POP:  s = UC_MPO0;
         default:    s = UC_DONE;
      endcase
      return s;
   endfunction

endpackage

// ----- hdl/tsm_ram.sv -----
module tsm_ram #(
   parameter int unsigned WIDTH = tsm_pkg::DATA_W,
   parameter int unsigned DEPTH = tsm_pkg::STORE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tsm_seq.sv -----
module tsm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tsm_pkg::flags_type  flags,
   output tsm_pkg::ctrl_type   ctrl,
   output logic                accept,
   output logic                emit
);

   tsm_pkg::step_type upc_ff, upc_in;
   tsm_pkg::step_type dispatch_target;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              jump;

   assign ctrl      = tsm_pkg::uc_word(upc_ff);
   assign req_ready = ctrl.is_idle;
   assign accept    = req_valid & ctrl.is_idle;
   // hold the finished beat in the sequencer until the output slot frees up
   assign emit      = ctrl.is_done & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   assign dispatch_target = flags.err ? tsm_pkg::UC_DONE : tsm_pkg::entry_of(flags.kind);

   always_comb begin
      case (ctrl.cond)
         tsm_pkg::C_NEXT:     jump = 1'b0;
         tsm_pkg::C_ALWAYS:   jump = 1'b1;
         tsm_pkg::C_LEN_ZERO: jump = flags.len_zero;
         tsm_pkg::C_PTR_SLOT: jump = flags.ptr_at_slot;
         tsm_pkg::C_PTR_LAST: jump = flags.ptr_at_last;
         tsm_pkg::C_DISPATCH: jump = 1'b1;
         default:             jump = 1'b0;
      endcase
   end

   always_comb begin
      if (ctrl.is_idle) begin
         upc_in = accept ? tsm_pkg::UC_DISPATCH : upc_ff;
      end else if (ctrl.is_done) begin
         upc_in = emit ? tsm_pkg::UC_IDLE : upc_ff;
      end else if (jump) begin
         upc_in = (ctrl.cond == tsm_pkg::C_DISPATCH) ? dispatch_target : ctrl.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= tsm_pkg::UC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= tsm_pkg::UC_LAST)
      else $error("microprogram counter left the control store");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      accept |=> upc_ff == tsm_pkg::UC_DISPATCH)
      else $error("accepted beat did not reach dispatch");

   a_emit_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff == tsm_pkg::UC_DONE))
      else $error("result raised outside the done step");

endmodule

// ----- hdl/tsm_datapath.sv -----
module tsm_datapath #(
   parameter int unsigned STORE_DEPTH = tsm_pkg::STORE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              emit,
   input  logic                              req_opcode,
   input  logic [1:0]                        req_stack_select,
   input  logic signed [tsm_pkg::DATA_W-1:0] req_push_value,
   input  tsm_pkg::ctrl_type                 ctrl,
   output tsm_pkg::flags_type                flags,
   output logic signed [tsm_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [1:0]                        rsp_status
);

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
   localparam int unsigned SW = CW + 2;
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   // stack geometry
   logic [CW-1:0] bot_ff, bot_in;
   logic [CW-1:0] top_ff, top_in;
   logic [AW-1:0] base_ff, base_in;
   logic [CW-1:0] len_ff, len_in;
   logic [AW-1:0] rot_ff, rot_in;
   logic [AW-1:0] ptr_ff, ptr_in;

   // latched request and result
   logic                      op_ff;
   logic [1:0]                sel_ff;
   logic [tsm_pkg::DATA_W-1:0] value_ff;
   tsm_pkg::status_type       st_ff, st_in;
   logic [tsm_pkg::DATA_W-1:0] res_ff;
   logic [tsm_pkg::DATA_W-1:0] out_value_ff;
   tsm_pkg::status_type       out_status_ff;

   logic [CW-1:0] end_w, endm1, end_r, end_r1, len_m1;
   logic [SW-1:0] occupancy;
   logic          full, empty;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr, ram_rd_addr;
   logic [tsm_pkg::DATA_W-1:0] ram_wr_data, ram_rd_data;

   assign end_w  = CW'(base_ff) + len_ff;
   assign endm1  = end_w - 1'b1;
   assign end_r  = end_w - CW'(rot_ff);
   assign end_r1 = end_r - 1'b1;
   assign len_m1 = len_ff - 1'b1;

   function automatic logic [AW-1:0] pick_addr(tsm_pkg::addr_sel_type s,
                                                logic [CW-1:0] bot, logic [CW-1:0] top,
                                                logic [AW-1:0] base, logic [CW-1:0] endw,
                                                logic [CW-1:0] endr1, logic [AW-1:0] ptr);
      logic [AW-1:0] a;
      case (s)
         tsm_pkg::A_BC:     a = AW'(bot);
         tsm_pkg::A_BCM1:   a = AW'(bot - 1'b1);
         tsm_pkg::A_TOPW:   a = AW'(DEPTH_C - 1'b1 - top);
         tsm_pkg::A_TOPR:   a = AW'(DEPTH_C - top);
         tsm_pkg::A_BASE:   a = base;
         tsm_pkg::A_BASEM1: a = base - 1'b1;
         tsm_pkg::A_END:    a = AW'(endw);
         tsm_pkg::A_ENDM1:  a = AW'(endw - 1'b1);
         tsm_pkg::A_END_R1: a = AW'(endr1);
         tsm_pkg::A_PTR:    a = ptr;
         tsm_pkg::A_PTRM1:  a = ptr - 1'b1;
         tsm_pkg::A_PTRP1:  a = ptr + 1'b1;
         default:           a = ptr;
      endcase
      return a;
   endfunction

   assign ram_wr_en   = ctrl.wr_en;
   assign ram_wr_addr = pick_addr(ctrl.wr_sel, bot_ff, top_ff, base_ff, end_w, end_r1, ptr_ff);
   assign ram_rd_addr = pick_addr(ctrl.rd_sel, bot_ff, top_ff, base_ff, end_w, end_r1, ptr_ff);
   assign ram_wr_data = (ctrl.wd_sel == tsm_pkg::WD_RAM) ? ram_rd_data : value_ff;

   tsm_ram #(
      .WIDTH (tsm_pkg::DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // status is judged against the geometry at the moment of the beat
   assign occupancy = SW'(bot_ff) + SW'(len_ff) + SW'(top_ff);
   assign full      = occupancy >= SW'(STORE_DEPTH);

   always_comb begin
      case (req_stack_select)
         tsm_pkg::SEL_BOTTOM: empty = (bot_ff == '0);
         tsm_pkg::SEL_TOP:    empty = (top_ff == '0);
         default:             empty = (len_ff == '0);
      endcase
   end

   always_comb begin
      if (req_opcode == tsm_pkg::OP_PUSH) begin
         st_in = full ? tsm_pkg::ST_FULL : tsm_pkg::ST_OK;
      end else begin
         st_in = empty ? tsm_pkg::ST_EMPTY : tsm_pkg::ST_OK;
      end
   end

   always_comb begin
      case (sel_ff)
         tsm_pkg::SEL_BOTTOM:
            flags.kind = (op_ff == tsm_pkg::OP_POP) ? tsm_pkg::K_BOT_POP : tsm_pkg::K_BOT_PUSH;
         tsm_pkg::SEL_TOP:
            flags.kind = (op_ff == tsm_pkg::OP_POP) ? tsm_pkg::K_TOP_POP : tsm_pkg::K_TOP_PUSH;
         default:
            flags.kind = (op_ff == tsm_pkg::OP_POP) ? tsm_pkg::K_MID_POP : tsm_pkg::K_MID_PUSH;
      endcase
      flags.err         = (st_ff != tsm_pkg::ST_OK);
      flags.len_zero    = (len_ff == '0);
      flags.ptr_at_slot = (CW'(ptr_ff) == end_r);
      flags.ptr_at_last = (CW'(ptr_ff) == endm1);
   end

   always_comb begin
      bot_in  = bot_ff;
      top_in  = top_ff;
      base_in = base_ff;
      len_in  = len_ff;
      rot_in  = rot_ff;
      case (ctrl.upd)
         tsm_pkg::UPD_NONE: begin
         end
         tsm_pkg::UPD_BOT_INC: begin
            bot_in = bot_ff + 1'b1;
         end
         tsm_pkg::UPD_BOT_DEC: begin
            bot_in = bot_ff - 1'b1;
         end
         tsm_pkg::UPD_TOP_INC: begin
            top_in = top_ff + 1'b1;
         end
         tsm_pkg::UPD_TOP_DEC: begin
            top_in = top_ff - 1'b1;
         end
         // rotation steps modulo the length; it stays below the length
         tsm_pkg::UPD_SLIDE_UP: begin
            base_in = base_ff + 1'b1;
            rot_in  = ((CW'(rot_ff) + 1'b1) == len_ff) ? '0 : rot_ff + 1'b1;
         end
         tsm_pkg::UPD_SLIDE_DOWN: begin
            base_in = base_ff - 1'b1;
            rot_in  = (rot_ff == '0) ? AW'(len_m1) : rot_ff - 1'b1;
         end
         tsm_pkg::UPD_MID_FIRST: begin
            base_in = AW'(bot_ff);
            rot_in  = '0;
            len_in  = CW'(1);
         end
         tsm_pkg::UPD_MID_INC: begin
            len_in = len_ff + 1'b1;
         end
         tsm_pkg::UPD_MID_DEC: begin
            len_in = len_m1;
            rot_in = (CW'(rot_ff) == len_m1) ? '0 : rot_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (ctrl.ptr_op)
         tsm_pkg::PTR_HOLD:      ptr_in = ptr_ff;
         tsm_pkg::PTR_LOAD_END:  ptr_in = AW'(end_w);
         tsm_pkg::PTR_LOAD_SLOT: ptr_in = AW'(end_r1);
         tsm_pkg::PTR_INC:       ptr_in = ptr_ff + 1'b1;
         tsm_pkg::PTR_DEC:       ptr_in = ptr_ff - 1'b1;
         default:                ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bot_ff  <= '0;
         top_ff  <= '0;
         base_ff <= '0;
         len_ff  <= '0;
         rot_ff  <= '0;
      end else begin
         bot_ff  <= bot_in;
         top_ff  <= top_in;
         base_ff <= base_in;
         len_ff  <= len_in;
         rot_ff  <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (accept) begin
         op_ff    <= req_opcode;
         sel_ff   <= req_stack_select;
         value_ff <= req_push_value;
         st_ff    <= st_in;
         res_ff   <= '0;
      end else if (ctrl.res_load) begin
         res_ff <= ram_rd_data;
      end
      if (emit) begin
         out_value_ff  <= res_ff;
         out_status_ff <= st_ff;
      end
   end

   assign rsp_pop_value = out_value_ff;
   assign rsp_status    = out_status_ff;

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occupancy <= SW'(STORE_DEPTH))
      else $error("stacks overran the store");

   a_rotation: assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0) ? (rot_ff == '0) : (CW'(rot_ff) < len_ff))
      else $error("rotation out of range for the middle length");

   a_middle_adjacent: assert property (@(posedge clock) disable iff (reset)
      (ctrl.is_idle && len_ff != '0) |-> (CW'(base_ff) == bot_ff))
      else $error("middle region detached from bottom stack");

endmodule

// ----- hdl/three_stacks_one_memory.sv -----
// An empty or full error goes from dispatch straight to the done step. A middle push or pop
// other than a first middle push shifts each word above the logical top, so its work grows
// with the middle rotation. One item is in work at a time; the sequencer returns to idle in
// the cycle after the result leaves it, where the next beat can be taken. The shift loop
// moves one word at a time through the single memory, a read step followed by a write step.
// Reset clears the stack geometry; the store itself is not cleared and needs no sweep.
module three_stacks_one_memory #(
   parameter int unsigned STORE_DEPTH = tsm_pkg::STORE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [1:0]                        req_stack_select,
   input  logic signed [tsm_pkg::DATA_W-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tsm_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [1:0]                        rsp_status
);

   tsm_pkg::ctrl_type  ctrl;
   tsm_pkg::flags_type flags;
   logic               accept;
   logic               emit;

   tsm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .ctrl      (ctrl),
      .accept    (accept),
      .emit      (emit)
   );

   tsm_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .emit             (emit),
      .req_opcode       (req_opcode),
      .req_stack_select (req_stack_select),
      .req_push_value   (req_push_value),
      .ctrl             (ctrl),
      .flags            (flags),
      .rsp_pop_value    (rsp_pop_value),
      .rsp_status       (rsp_status)
   );

endmodule
